### hdl/slim_pkg.sv
// shared types and constants for the sorted list insert and merge block
`timescale 1ns / 1ps

package slim_pkg;

    localparam int DATA_W      = 32;
    localparam int OUT_CNT_W   = 6;
    localparam int OUT_CNT_MAX = 63;
    localparam int MAX_RESULTS = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_MERGE  = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_WR,
        ST_MRG_RD,
        ST_MRG_WR,
        ST_RD_RD,
        ST_RD_OUT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        op_t                       operation;
        logic                      list_select;
        logic signed [DATA_W-1:0]  value;
    } in_beat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  entry_value;
        logic [OUT_CNT_W-1:0]      entry_count;
        logic                      is_empty;
        logic                      overflowed;
        logic                      last_of_run;
    } out_beat_t;

endpackage

### hdl/slim_ram.sv
// list entry storage, one write port and one registered read port
`timescale 1ns / 1ps

module slim_ram
    import slim_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  logic signed [DATA_W-1:0] wdata,
    input  logic                     re,
    input  logic [AW-1:0]            raddr,
    output logic signed [DATA_W-1:0] rdata
);

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/slim_ctrl.sv
// sequencer with shared signed comparator, list counters and result register
`timescale 1ns / 1ps

module slim_ctrl
    import slim_pkg::*;
#(
    parameter int CAP = 32,
    parameter int IW  = 5,
    parameter int CW  = 6
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  in_beat_t                 s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output out_beat_t                m_data,
    output logic                     a_we,
    output logic [IW-1:0]            a_waddr,
    output logic signed [DATA_W-1:0] a_wdata,
    output logic [IW-1:0]            a_raddr,
    input  logic signed [DATA_W-1:0] a_rdata,
    output logic                     b_we,
    output logic [IW-1:0]            b_waddr,
    output logic signed [DATA_W-1:0] b_wdata,
    output logic [IW-1:0]            b_raddr,
    input  logic signed [DATA_W-1:0] b_rdata,
    output logic                     rd_en
);

    localparam int LIM_MAX = (CAP < MAX_RESULTS) ? CAP : MAX_RESULTS;
    localparam logic [CW-1:0] CAP_C = CW'(CAP);
    localparam logic [CW-1:0] LIM_C = CW'(LIM_MAX);

    state_t                   state_reg, state_next;
    op_t                      op_reg, op_next;
    logic                     sel_reg, sel_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic [CW-1:0]            cnt_a_reg, cnt_a_next;
    logic [CW-1:0]            cnt_b_reg, cnt_b_next;
    logic [CW-1:0]            ptr_reg, ptr_next;
    logic [CW-1:0]            jb_reg, jb_next;
    logic [CW-1:0]            lim_reg, lim_next;
    logic                     ovf_reg, ovf_next;
    logic                     m_valid_reg, m_valid_next;
    out_beat_t                m_data_reg, m_data_next;

    logic [CW-1:0]            in_cnt, sel_cnt, room, jb_init;
    logic [CW-1:0]            ptr_dec, jb_dec, mrg_pos, ptr_inc, rpt_cnt;
    logic signed [DATA_W-1:0] rd_sel, cmp_lhs, cmp_rhs;
    logic                     cmp_ge, out_free, rd_last;
    logic                     wr_en, wr_to_b;
    logic [IW-1:0]            wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic [OUT_CNT_W-1:0]     cnt_sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_a_reg   <= '0;
            cnt_b_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_a_reg   <= cnt_a_next;
            cnt_b_reg   <= cnt_b_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        sel_reg    <= sel_next;
        val_reg    <= val_next;
        ptr_reg    <= ptr_next;
        jb_reg     <= jb_next;
        lim_reg    <= lim_next;
        ovf_reg    <= ovf_next;
        m_data_reg <= m_data_next;
    end

    assign in_cnt   = s_data.list_select ? cnt_b_reg : cnt_a_reg;
    assign sel_cnt  = sel_reg ? cnt_b_reg : cnt_a_reg;
    assign room     = CAP_C - cnt_a_reg;
    assign jb_init  = (cnt_b_reg > room) ? room : cnt_b_reg;
    assign ptr_dec  = ptr_reg - 1'b1;
    assign ptr_inc  = ptr_reg + 1'b1;
    assign jb_dec   = jb_reg - 1'b1;
    assign mrg_pos  = ptr_reg + jb_dec;
    assign rd_sel   = sel_reg ? b_rdata : a_rdata;
    assign out_free = !m_valid_reg || m_ready;
    assign rd_last  = (ptr_inc == lim_reg);
    assign rpt_cnt  = (op_reg == OP_MERGE) ? cnt_a_reg : sel_cnt;
    assign cnt_sat  = (int'(rpt_cnt) > OUT_CNT_MAX) ? OUT_CNT_W'(OUT_CNT_MAX)
                                                    : OUT_CNT_W'(rpt_cnt);

    // shared signed comparator
    assign cmp_lhs = (state_reg == ST_MRG_WR) ? b_rdata : rd_sel;
    assign cmp_rhs = (state_reg == ST_MRG_WR) ? a_rdata : val_reg;
    assign cmp_ge  = (cmp_lhs >= cmp_rhs);

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        sel_next     = sel_reg;
        val_next     = val_reg;
        cnt_a_next   = cnt_a_reg;
        cnt_b_next   = cnt_b_reg;
        ptr_next     = ptr_reg;
        jb_next      = jb_reg;
        lim_next     = lim_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        wr_en        = 1'b0;
        wr_to_b      = sel_reg;
        wr_addr      = ptr_reg[IW-1:0];
        wr_data      = val_reg;
        rd_en        = 1'b0;
        a_raddr      = ptr_dec[IW-1:0];
        b_raddr      = ptr_dec[IW-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next  = s_data.operation;
                    sel_next = s_data.list_select;
                    val_next = s_data.value;
                    ovf_next = 1'b0;
                    unique case (s_data.operation)
                        OP_INSERT: begin
                            if (in_cnt == CAP_C) begin
                                ovf_next   = 1'b1;
                                state_next = ST_EMIT;
                            end else begin
                                ptr_next   = in_cnt;
                                state_next = ST_INS_RD;
                            end
                        end
                        OP_MERGE: begin
                            ovf_next   = (cnt_b_reg > room);
                            ptr_next   = cnt_a_reg;
                            jb_next    = jb_init;
                            cnt_a_next = cnt_a_reg + jb_init;
                            cnt_b_next = '0;
                            state_next = ST_MRG_RD;
                        end
                        OP_READ: begin
                            if (in_cnt == '0) begin
                                state_next = ST_EMIT;
                            end else begin
                                ptr_next   = '0;
                                lim_next   = (int'(in_cnt) > LIM_MAX) ? LIM_C : in_cnt;
                                state_next = ST_RD_RD;
                            end
                        end
                        OP_CLEAR: begin
                            if (s_data.list_select) begin
                                cnt_b_next = '0;
                            end else begin
                                cnt_a_next = '0;
                            end
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_INS_RD: begin
                if (ptr_reg == '0) begin
                    wr_en = 1'b1;
                    if (sel_reg) begin
                        cnt_b_next = cnt_b_reg + 1'b1;
                    end else begin
                        cnt_a_next = cnt_a_reg + 1'b1;
                    end
                    state_next = ST_EMIT;
                end else begin
                    rd_en      = 1'b1;
                    state_next = ST_INS_WR;
                end
            end
            ST_INS_WR: begin
                wr_en = 1'b1;
                if (cmp_ge) begin
                    wr_data    = rd_sel;
                    ptr_next   = ptr_dec;
                    state_next = ST_INS_RD;
                end else begin
                    if (sel_reg) begin
                        cnt_b_next = cnt_b_reg + 1'b1;
                    end else begin
                        cnt_a_next = cnt_a_reg + 1'b1;
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_MRG_RD: begin
                if (jb_reg == '0) begin
                    state_next = ST_EMIT;
                end else begin
                    rd_en      = 1'b1;
                    b_raddr    = jb_dec[IW-1:0];
                    state_next = ST_MRG_WR;
                end
            end
            ST_MRG_WR: begin
                // fill list a from the tail, larger of the two list tails first
                wr_en   = 1'b1;
                wr_to_b = 1'b0;
                wr_addr = mrg_pos[IW-1:0];
                if (ptr_reg != '0 && !cmp_ge) begin
                    wr_data  = a_rdata;
                    ptr_next = ptr_dec;
                end else begin
                    wr_data = b_rdata;
                    jb_next = jb_dec;
                end
                state_next = ST_MRG_RD;
            end
            ST_RD_RD: begin
                rd_en      = 1'b1;
                a_raddr    = ptr_reg[IW-1:0];
                b_raddr    = ptr_reg[IW-1:0];
                state_next = ST_RD_OUT;
            end
            ST_RD_OUT: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_data_next.entry_value = rd_sel;
                    m_data_next.entry_count = cnt_sat;
                    m_data_next.is_empty    = 1'b0;
                    m_data_next.overflowed  = 1'b0;
                    m_data_next.last_of_run = rd_last;
                    ptr_next                = ptr_inc;
                    state_next              = rd_last ? ST_IDLE : ST_RD_RD;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_data_next.entry_value = '0;
                    m_data_next.entry_count = cnt_sat;
                    m_data_next.is_empty    = (op_reg == OP_READ);
                    m_data_next.overflowed  = ovf_reg;
                    m_data_next.last_of_run = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
        endcase
    end

    assign a_we    = wr_en && !wr_to_b;
    assign b_we    = wr_en && wr_to_b;
    assign a_waddr = wr_addr;
    assign b_waddr = wr_addr;
    assign a_wdata = wr_data;
    assign b_wdata = wr_data;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### hdl/sorted_list_insert_merge.sv
// top level: two sorted list memories under one insert, merge and read sequencer
// insert: entries not below the new value move one place toward the tail, then the value is written
// merge: list b entries are placed into list a from the tail, moving a entries behind them
// read out: one beat per entry, up to MAX_RESULTS; clear, empty read, insert into full list: a single beat
// one item at a time; while a result beat is stalled, the sequencer waits to give its next beat until it is taken
// reset clears both counts and the result valid flag; result data and entry memories are not cleared
`timescale 1ns / 1ps

module sorted_list_insert_merge
    import slim_pkg::*;
#(
    parameter int LIST_CAPACITY = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    localparam int IW = $clog2(LIST_CAPACITY);
    localparam int CW = $clog2(LIST_CAPACITY + 1);

    logic                     a_we, b_we, rd_en;
    logic [IW-1:0]            a_waddr, a_raddr, b_waddr, b_raddr;
    logic signed [DATA_W-1:0] a_wdata, a_rdata, b_wdata, b_rdata;

    slim_ctrl #(
        .CAP (LIST_CAPACITY),
        .IW  (IW),
        .CW  (CW)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .a_we    (a_we),
        .a_waddr (a_waddr),
        .a_wdata (a_wdata),
        .a_raddr (a_raddr),
        .a_rdata (a_rdata),
        .b_we    (b_we),
        .b_waddr (b_waddr),
        .b_wdata (b_wdata),
        .b_raddr (b_raddr),
        .b_rdata (b_rdata),
        .rd_en   (rd_en)
    );

    slim_ram #(
        .DEPTH (LIST_CAPACITY),
        .AW    (IW)
    ) u_list_a (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .re    (rd_en),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    slim_ram #(
        .DEPTH (LIST_CAPACITY),
        .AW    (IW)
    ) u_list_b (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .re    (rd_en),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

endmodule
